/* rtl/gray_range_contrast_lut_core_macros.svh */
// Assertion macros shared by the contrast engine RTL.
`ifndef GRAY_RANGE_CONTRAST_LUT_CORE_MACROS_SVH
`define GRAY_RANGE_CONTRAST_LUT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GRCLUT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GRCLUT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/grclut_pkg.sv */
// Types and constants of the gray-level contrast engine.
package grclut_pkg;

    localparam int LEVELS    = 256;
    localparam int PIX_W     = 8;
    localparam int DIV_STEPS = 16;

    localparam logic [PIX_W-1:0] LAST_LEVEL  = PIX_W'(LEVELS - 1);
    localparam logic [PIX_W-1:0] MAX_TONE    = 8'hff;
    localparam logic [15:0]      STRETCH_NUM = 16'hffff;
    localparam int               ZEBRA_DIV   = 15;
    localparam logic [12:0]      ZEBRA_TOP   = 13'(255 * ZEBRA_DIV);
    // floor(x/15) == ((x+1) * (65535/15)) >> 16 for x up to 4095
    localparam logic [12:0]      ZEBRA_RECIP = 13'(65535 / ZEBRA_DIV);

    typedef enum logic [1:0] {
        OP_OBSERVE = 2'd0,
        OP_FINISH  = 2'd1,
        OP_MAP     = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        MODE_IDENTITY = 2'd0,
        MODE_STRETCH  = 2'd1,
        MODE_ZEBRA    = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FILL,
        ST_REPORT
    } t_state;

    typedef enum logic {
        KIND_RANGE  = 1'b0,
        KIND_MAPPED = 1'b1
    } t_kind;

endpackage

/* rtl/grclut_in_if.sv */
// Input channel: one pixel item with its opcode.
interface grclut_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   opcode;
    logic [grclut_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output opcode, output pixel, input ready);
    modport sink   (input valid, input opcode, input pixel, output ready);
endinterface

/* rtl/grclut_out_if.sv */
// Output channel: one result item, a range report or a mapped pixel.
interface grclut_out_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [grclut_pkg::PIX_W-1:0] mapped_pixel;
    logic [grclut_pkg::PIX_W-1:0] range_low;
    logic [grclut_pkg::PIX_W-1:0] range_high;

    modport source (output valid, output kind, output mapped_pixel, output range_low,
                    output range_high, input ready);
    modport sink   (input valid, input kind, input mapped_pixel, input range_low,
                    input range_high, output ready);
endinterface

/* rtl/gray_range_contrast_lut_core.sv */
// Gray-level contrast engine: range tracking, tone table build and pixel mapping.
// Usage
//   i_pix carries items with an opcode and a pixel: observe marks a gray level,
//   finish reports the lowest and highest marked level and rebuilds the
//   256-entry tone table, map looks a pixel up in that table. o_res carries
//   results: a range report (kind 0) per finish, a mapped pixel (kind 1) per map.
//   Observe items and unused opcodes give no result. i_cfg_we/i_cfg_data write
//   the table mode (0 identity, 1 stretch, 2 zebra); the user must do so only while
//   the engine is idle, not enforced by the block; it is sampled at an accepted finish.
// Timing
//   Observe and map items are taken one per cycle while o_res does not stall.
//   A mapped pixel passes the table read register, then the output register.
//   A finish holds i_pix.ready low while the bit-serial 0xffff/(high-low)
//   divider runs, while the tone table is written and until the report is
//   loaded into the read stage; the report then moves on to o_res.
// Reset and stalls
//   Reset (synchronous, active low) empties the range tracker, drops all items
//   in flight and sets mode 0. The tone table is not cleared; map only after a
//   finish. If o_res stalls, one result waits in the output register and one
//   more in the read stage; further items are then held off by i_pix.ready.
`include "gray_range_contrast_lut_core_macros.svh"

module gray_range_contrast_lut_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    grclut_in_if.sink                    i_pix,
    grclut_out_if.source                 o_res,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_data
);
    import grclut_pkg::*;

    // Control registers
    t_state           r_state, n_state;
    logic [1:0]       r_cfg_mode, n_cfg_mode;
    logic [1:0]       r_mode, n_mode;
    logic             r_seen, n_seen;
    logic [PIX_W-1:0] r_min, n_min;
    logic [PIX_W-1:0] r_max, n_max;
    logic [PIX_W-1:0] r_lo, n_lo;
    logic [PIX_W-1:0] r_hi, n_hi;
    logic [3:0]       r_cnt, n_cnt;
    logic [7:0]       r_rem, n_rem;
    logic [15:0]      r_quo, n_quo;
    logic [PIX_W-1:0] r_idx, n_idx;
    logic [15:0]      r_acc, n_acc;
    logic [12:0]      r_zacc, n_zacc;
    logic             r_p1_vld, n_p1_vld;
    logic             r_out_vld, n_out_vld;

    // Payload registers
    logic             r_p1_kind, r_out_kind;
    logic [PIX_W-1:0] r_p1_lo, r_p1_hi;
    logic [PIX_W-1:0] r_out_mapped, r_out_lo, r_out_hi;
    logic [PIX_W-1:0] r_rdata;

    // Tone table
    logic [PIX_W-1:0] r_tone [LEVELS];

    logic             in_acc;
    logic             p1_move;
    logic             p1_load;
    logic             p1_load_kind;
    logic             rd_en;
    logic             wr_en;
    logic [PIX_W-1:0] wr_data;
    logic [PIX_W-1:0] range_d;
    logic [8:0]       div_trial;
    logic             div_ge;
    logic [25:0]      zebra_prod;
    logic [12:0]      zacc_sum;

    // Output handshake and read-stage movement
    assign p1_move     = r_p1_vld && (!r_out_vld || o_res.ready);
    assign i_pix.ready = (r_state == ST_IDLE) && (!r_p1_vld || p1_move);
    assign in_acc      = i_pix.valid && i_pix.ready;

    assign o_res.valid        = r_out_vld;
    assign o_res.kind         = r_out_kind;
    assign o_res.mapped_pixel = r_out_mapped;
    assign o_res.range_low    = r_out_lo;
    assign o_res.range_high   = r_out_hi;

    // Datapath helpers: divider step, zebra quotient, table data
    assign range_d    = r_hi - r_lo;
    assign div_trial  = {r_rem, STRETCH_NUM[DIV_STEPS - 1 - 32'(r_cnt)]};
    assign div_ge     = div_trial >= {1'b0, range_d};
    assign zebra_prod = 26'((r_zacc + 13'd1) * ZEBRA_RECIP);
    assign zacc_sum   = r_zacc + {5'd0, range_d};

    always_comb begin
        case (r_mode)
            MODE_STRETCH: begin
                if (r_idx < r_lo) begin
                    wr_data = '0;
                end else if (r_idx < r_hi) begin
                    wr_data = r_acc[15:8];
                end else begin
                    wr_data = MAX_TONE;
                end
            end
            MODE_ZEBRA: wr_data = zebra_prod[23:16];
            default:    wr_data = r_idx;
        endcase
    end

    // Next state and control
    always_comb begin
        n_state      = r_state;
        n_cfg_mode   = i_cfg_we ? i_cfg_data : r_cfg_mode;
        n_mode       = r_mode;
        n_seen       = r_seen;
        n_min        = r_min;
        n_max        = r_max;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_cnt        = r_cnt;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_idx        = r_idx;
        n_acc        = r_acc;
        n_zacc       = r_zacc;
        p1_load      = 1'b0;
        p1_load_kind = KIND_RANGE;
        rd_en        = 1'b0;
        wr_en        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_pix.opcode)
                        OP_OBSERVE: begin
                            n_seen = 1'b1;
                            if (!r_seen || i_pix.pixel < r_min) n_min = i_pix.pixel;
                            if (!r_seen || i_pix.pixel > r_max) n_max = i_pix.pixel;
                        end
                        OP_FINISH: begin
                            n_lo    = r_seen ? r_min : '0;
                            n_hi    = r_seen ? r_max : '0;
                            n_seen  = 1'b0;
                            n_mode  = r_cfg_mode;
                            n_cnt   = '0;
                            n_rem   = '0;
                            n_quo   = '0;
                            n_idx   = '0;
                            n_acc   = '0;
                            n_zacc  = '0;
                            n_state = ST_DIV;
                        end
                        OP_MAP: begin
                            rd_en        = 1'b1;
                            p1_load      = 1'b1;
                            p1_load_kind = KIND_MAPPED;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                // one quotient bit of 0xffff / (high - low) per cycle
                n_rem = div_ge ? 8'(div_trial - {1'b0, range_d}) : div_trial[7:0];
                n_quo = {r_quo[14:0], div_ge};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(DIV_STEPS - 1)) n_state = ST_FILL;
            end
            ST_FILL: begin
                wr_en = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx >= r_lo && r_idx < r_hi) n_acc = r_acc + r_quo;
                // zebra accumulator moves once per pair of levels
                if (r_idx[0]) n_zacc = (zacc_sum > ZEBRA_TOP) ? '0 : zacc_sum;
                if (r_idx == LAST_LEVEL) n_state = ST_REPORT;
            end
            ST_REPORT: begin
                if (!r_p1_vld || p1_move) begin
                    p1_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        n_p1_vld  = p1_load ? 1'b1 : (p1_move ? 1'b0 : r_p1_vld);
        n_out_vld = p1_move ? 1'b1 : ((o_res.ready) ? 1'b0 : r_out_vld);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cfg_mode <= MODE_IDENTITY;
            r_mode     <= MODE_IDENTITY;
            r_seen     <= 1'b0;
            r_min      <= '0;
            r_max      <= '0;
            r_lo       <= '0;
            r_hi       <= '0;
            r_cnt      <= '0;
            r_rem      <= '0;
            r_quo      <= '0;
            r_idx      <= '0;
            r_acc      <= '0;
            r_zacc     <= '0;
            r_p1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cfg_mode <= n_cfg_mode;
            r_mode     <= n_mode;
            r_seen     <= n_seen;
            r_min      <= n_min;
            r_max      <= n_max;
            r_lo       <= n_lo;
            r_hi       <= n_hi;
            r_cnt      <= n_cnt;
            r_rem      <= n_rem;
            r_quo      <= n_quo;
            r_idx      <= n_idx;
            r_acc      <= n_acc;
            r_zacc     <= n_zacc;
            r_p1_vld   <= n_p1_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // Read stage and output register payload
    always_ff @(posedge i_clk) begin
        if (p1_load) begin
            r_p1_kind <= p1_load_kind;
            r_p1_lo   <= (p1_load_kind == KIND_MAPPED) ? '0 : r_lo;
            r_p1_hi   <= (p1_load_kind == KIND_MAPPED) ? '0 : r_hi;
        end
        if (p1_move) begin
            r_out_kind   <= r_p1_kind;
            r_out_mapped <= (r_p1_kind == KIND_MAPPED) ? r_rdata : '0;
            r_out_lo     <= r_p1_lo;
            r_out_hi     <= r_p1_hi;
        end
    end

    // Tone table memory: one write port for the build, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) r_tone[r_idx] <= wr_data;
        if (rd_en) r_rdata <= r_tone[i_pix.pixel];
    end

    // Checks
    `GRCLUT_ASSERT_NXT(a_finish_starts_div, i_clk, i_rst_n,
        in_acc && (i_pix.opcode == OP_FINISH), r_state == ST_DIV,
        "finish item did not start the divider")
    `GRCLUT_ASSERT_NXT(a_fill_ends_report, i_clk, i_rst_n,
        (r_state == ST_FILL) && (r_idx == LAST_LEVEL), r_state == ST_REPORT,
        "table build did not end in the report")
    `GRCLUT_ASSERT_IMP(a_range_ordered, i_clk, i_rst_n,
        r_seen, r_min <= r_max, "range tracker low above high")

endmodule
